FILE: rtl/core/wbss_pkg.sv
package wbss_pkg;

   localparam int MAX_SIGNATURE = 32;
   localparam int OFFSET_BITS   = 32;
   localparam int ADDR_BITS     = 48;
   localparam int LEN_BITS      = $clog2(MAX_SIGNATURE + 1);
   localparam int IDX_BITS      = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_IDX_BITS  = 3;
   localparam int SIG_WORDS     = 4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SIG_0_7   = 3'd0,
      REG_SIG_8_15  = 3'd1,
      REG_SIG_16_23 = 3'd2,
      REG_SIG_24_31 = 3'd3,
      REG_WILDCARD  = 3'd4,
      REG_LENGTH    = 3'd5,
      REG_BASE      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] match_address;
   } result_type;

endpackage

FILE: rtl/core/wbss_cell.sv
module wbss_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wbss_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_hit,
   input  logic [7:0]             data_byte,
   input  logic [7:0]             pattern_byte,
   input  logic                   wild,
   output logic                   hit_ff,
   output logic                   hit_in
);

   // prefix of the signature up to this position ends on the incoming byte
   assign hit_in = prev_hit && (wild || (data_byte == pattern_byte));

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         hit_ff <= 1'b0;
      end else if (ctrl.shift) begin
         hit_ff <= hit_in;
      end
   end

endmodule

FILE: rtl/core/wbss_skid.sv
module wbss_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wbss_pkg::result_type push_data,
   output logic                 can_accept,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wbss_pkg::result_type out_data
);

   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   wbss_pkg::result_type out_ff;
   wbss_pkg::result_type skid_ff;
   logic                 load_out;

   assign load_out   = !out_valid_ff || out_ready;
   assign can_accept = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load_out) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         if (skid_valid_ff) begin
            out_ff  <= skid_ff;
            skid_ff <= push_data;
         end else begin
            out_ff  <= push_data;
         end
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

FILE: rtl/core/wildcard_byte_signature_scan.sv
// Scans a byte stream (one byte per req beat, tlast on the final byte of an image) for the
// first offset where a signature of up to 32 bytes matches, wildcard positions matching any
// byte. It takes one byte per cycle while the output buffer has room: a row of 32 cells, one
// per signature position, each holding whether the signature prefix ending there has matched
// so far and passing it to its neighbor on each scanned byte. A result (found in tuser, base
// address plus offset in tdata) is queued on the deciding byte; a no-match result is sent on the
// tlast beat. After a match, bytes are dropped until tlast. A two-entry output buffer keeps
// input flowing while a result waits. Program the CSRs (64-bit, register i at byte 8*i) only
// while idle. The offset counter saturates at 2^32-1; bytes past that are never matched.
module wildcard_byte_signature_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] data_byte
   input  logic                                 req_tlast,   // end_of_image
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wbss_pkg::ADDR_BITS-1:0]       rsp_tdata,   // [47:0] match_address
   output logic                                 rsp_tuser,   // [0] found
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wbss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wbss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wbss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   logic [wbss_pkg::CSR_DATA_BITS-1:0] sig_ff [wbss_pkg::SIG_WORDS];
   logic [wbss_pkg::MAX_SIGNATURE-1:0] wild_ff;
   logic [wbss_pkg::LEN_BITS-1:0]      length_ff;
   logic [wbss_pkg::ADDR_BITS-1:0]     base_ff;

   logic [wbss_pkg::OFFSET_BITS-1:0]   bytes_seen_ff;
   logic [wbss_pkg::OFFSET_BITS-1:0]   bytes_seen_in;
   logic                               reported_ff;

   wbss_pkg::reg_index_type            csr_index;
   logic                               csr_write;

   logic [wbss_pkg::LEN_BITS-1:0]      len_eff;
   logic [wbss_pkg::IDX_BITS-1:0]      last_idx;
   logic [wbss_pkg::MAX_SIGNATURE-1:0] hit_reg;
   logic [wbss_pkg::MAX_SIGNATURE-1:0] hit_next;
   logic [8*wbss_pkg::CSR_DATA_BITS/2-1:0] sig_flat;

   logic                               accept;
   logic                               active;
   logic                               counted;
   logic                               match;
   logic                               emit;
   logic [wbss_pkg::OFFSET_BITS-1:0]   offset;
   wbss_pkg::cell_ctrl_type            cell_ctrl;
   wbss_pkg::result_type               result;
   wbss_pkg::result_type               rsp_data;
   logic                               can_accept;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_index  = wbss_pkg::reg_index_type'(csr_paddr[wbss_pkg::CSR_ADDR_BITS-1 -: 3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wbss_pkg::SIG_WORDS; i++) begin
            sig_ff[i] <= '0;
         end
         wild_ff   <= '0;
         length_ff <= wbss_pkg::LEN_BITS'(1);
         base_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            wbss_pkg::REG_SIG_0_7:   sig_ff[0] <= csr_pwdata;
            wbss_pkg::REG_SIG_8_15:  sig_ff[1] <= csr_pwdata;
            wbss_pkg::REG_SIG_16_23: sig_ff[2] <= csr_pwdata;
            wbss_pkg::REG_SIG_24_31: sig_ff[3] <= csr_pwdata;
            wbss_pkg::REG_WILDCARD:  wild_ff   <= csr_pwdata[wbss_pkg::MAX_SIGNATURE-1:0];
            wbss_pkg::REG_LENGTH:    length_ff <= csr_pwdata[wbss_pkg::LEN_BITS-1:0];
            wbss_pkg::REG_BASE:      base_ff   <= csr_pwdata[wbss_pkg::ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wbss_pkg::REG_SIG_0_7:   csr_prdata = sig_ff[0];
         wbss_pkg::REG_SIG_8_15:  csr_prdata = sig_ff[1];
         wbss_pkg::REG_SIG_16_23: csr_prdata = sig_ff[2];
         wbss_pkg::REG_SIG_24_31: csr_prdata = sig_ff[3];
         wbss_pkg::REG_WILDCARD:  csr_prdata = wbss_pkg::CSR_DATA_BITS'(wild_ff);
         wbss_pkg::REG_LENGTH:    csr_prdata = wbss_pkg::CSR_DATA_BITS'(length_ff);
         wbss_pkg::REG_BASE:      csr_prdata = wbss_pkg::CSR_DATA_BITS'(base_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign sig_flat = {sig_ff[3], sig_ff[2], sig_ff[1], sig_ff[0]};

   // length clamped to 1..MAX_SIGNATURE
   always_comb begin
      if (length_ff == '0) begin
         len_eff = wbss_pkg::LEN_BITS'(1);
      end else if (length_ff > wbss_pkg::LEN_BITS'(wbss_pkg::MAX_SIGNATURE)) begin
         len_eff = wbss_pkg::LEN_BITS'(wbss_pkg::MAX_SIGNATURE);
      end else begin
         len_eff = length_ff;
      end
   end
   assign last_idx = wbss_pkg::IDX_BITS'(len_eff - wbss_pkg::LEN_BITS'(1));

   // scan control
   assign req_tready = can_accept;
   assign accept     = req_tvalid && req_tready;
   assign active     = !reported_ff;
   assign counted    = (bytes_seen_ff != '1);
   assign bytes_seen_in = bytes_seen_ff + wbss_pkg::OFFSET_BITS'(1);
   assign match      = active && counted && hit_next[last_idx];
   assign emit       = accept && (match || (active && req_tlast));
   assign offset     = bytes_seen_in - wbss_pkg::OFFSET_BITS'(len_eff);

   assign cell_ctrl.clear = accept && req_tlast;
   assign cell_ctrl.shift = accept && active;

   always_comb begin
      result.found         = match;
      result.match_address = match ? (base_ff + wbss_pkg::ADDR_BITS'(offset)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         reported_ff   <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            bytes_seen_ff <= '0;
            reported_ff   <= 1'b0;
         end else if (active) begin
            if (counted) begin
               bytes_seen_ff <= bytes_seen_in;
            end
            reported_ff <= match;
         end
      end
   end

   // row of match cells, cell j tracks the signature prefix 0..j
   for (genvar j = 0; j < wbss_pkg::MAX_SIGNATURE; j++) begin : g_cell
      logic prev_hit;
      if (j == 0) begin : g_head
         assign prev_hit = 1'b1;
      end else begin : g_link
         assign prev_hit = hit_reg[j-1];
      end
      wbss_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .prev_hit     (prev_hit),
         .data_byte    (req_tdata),
         .pattern_byte (sig_flat[8*j +: 8]),
         .wild         (wild_ff[j]),
         .hit_ff       (hit_reg[j]),
         .hit_in       (hit_next[j])
      );
   end

   wbss_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_data  (result),
      .can_accept (can_accept),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data.match_address;
   assign rsp_tuser = rsp_data.found;

endmodule

FILE: verif/tb_wildcard_byte_signature_scan.sv
`timescale 1ns / 100ps

module tb_wildcard_byte_signature_scan;
   import wbss_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] UNUSED_INDEX = 3'd7;
   localparam int BEAT_TARGET  = 1120;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [7:0] data_byte;
      logic       last;
   } image_beat_type;

   typedef struct {
      logic                 found;
      logic [ADDR_BITS-1:0] address;
   } scan_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;    // [7:0] data_byte
   logic                     req_tlast = 1'b0;  // [0] end_of_image
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [ADDR_BITS-1:0]     rsp_tdata;         // [47:0] match_address
   logic                     rsp_tuser;         // [0] found
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   wildcard_byte_signature_scan uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // register mirror
   logic [63:0]          sig_word [SIG_WORDS];
   logic [31:0]          wild_mask;
   logic [5:0]           sig_len;
   logic [ADDR_BITS-1:0] base_addr;

   // scan state
   logic [7:0]  window_bytes [MAX_SIGNATURE];
   logic [31:0] scan_offset;
   logic        scan_reported;

   image_beat_type  image_beats [$];
   scan_report_type pending_reports [$];

   int  beats_queued   = 0;
   int  beats_accepted = 0;
   int  images_queued  = 0;
   int  setups_done    = 0;
   int  matches_seen   = 0;
   int  misses_seen    = 0;
   int  errors         = 0;
   bit  no_idle        = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout: %0d reports still pending", pending_reports.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int active_length();
      if (sig_len == 0) return 1;
      if (sig_len > MAX_SIGNATURE) return MAX_SIGNATURE;
      return int'(sig_len);
   endfunction

   function automatic logic [7:0] pattern_at(int j);
      return sig_word[2'(j >> 3)][(j & 7) * 8 +: 8];
   endfunction

   task automatic clear_scan();
      for (int k = 0; k < MAX_SIGNATURE; k++) window_bytes[k] = 8'h00;
      scan_offset   = '0;
      scan_reported = 1'b0;
   endtask

   task automatic advance_scan(input logic [7:0] data_byte, input logic last);
      int              len;
      logic            hit;
      logic            produced;
      scan_report_type rpt;
      produced = 1'b0;
      if (!scan_reported) begin
         len = active_length();
         for (int k = MAX_SIGNATURE - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
         window_bytes[0] = data_byte;
         if (scan_offset != '1) begin
            scan_offset = scan_offset + 1;
            if (scan_offset >= 32'(len)) begin
               hit = 1'b1;
               for (int j = 0; j < len; j++)
                  if (!wild_mask[j] && window_bytes[len-1-j] != pattern_at(j)) hit = 1'b0;
               if (hit) begin
                  rpt.found   = 1'b1;
                  rpt.address = base_addr + ADDR_BITS'(scan_offset - 32'(len));
                  pending_reports.insert(pending_reports.size(), rpt);
                  scan_reported = 1'b1;
                  produced      = 1'b1;
               end
            end
         end
         if (last && !produced) begin
            rpt.found   = 1'b0;
            rpt.address = '0;
            pending_reports.insert(pending_reports.size(), rpt);
         end
      end
      if (last) clear_scan();
   endtask

   // driver
   always @(posedge clock) begin
      image_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_scan(req_tdata, req_tlast);
            beats_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (image_beats.size() > 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
               nxt = image_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data_byte;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      scan_report_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected report found=%0b address=%h", $time, rsp_tuser,
                        rsp_tdata);
               errors++;
            end else begin
               exp_r = pending_reports.pop_front();
               if (exp_r.found) matches_seen++;
               else misses_seen++;
               if (rsp_tuser !== exp_r.found) begin
                  $display("%0t: found mismatch, expected %0b actual %0b", $time,
                           exp_r.found, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata !== exp_r.address) begin
                  $display("%0t: match_address mismatch, expected %h actual %h", $time,
                           exp_r.address, rsp_tdata);
                  errors++;
               end
            end
         end
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 34);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_SIG_0_7, REG_SIG_8_15, REG_SIG_16_23, REG_SIG_24_31: sig_word[idx[1:0]] = value;
         REG_WILDCARD: wild_mask = value[31:0];
         REG_LENGTH:   sig_len   = value[5:0];
         REG_BASE:     base_addr = value[ADDR_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic push_beat(input logic [7:0] data_byte, input logic last);
      image_beat_type b;
      b.data_byte = data_byte;
      b.last      = last;
      image_beats.insert(image_beats.size(), b);
      beats_queued++;
      if (last) images_queued++;
   endtask

   // all beats taken, all reports back, then let the pipe empty
   task automatic settle();
      while (beats_accepted != beats_queued || pending_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic randomize_setup();
      logic [5:0]           len;
      logic [31:0]          mask;
      logic [ADDR_BITS-1:0] base;
      for (int w = 0; w < SIG_WORDS; w++) begin
         case ($urandom_range(0, 7))
            0:       csr_write(CSR_IDX_BITS'(w), 64'h0);
            1:       csr_write(CSR_IDX_BITS'(w), '1);
            default: csr_write(CSR_IDX_BITS'(w), {$urandom, $urandom});
         endcase
      end
      case ($urandom_range(0, 5))
         0:       mask = 32'h0;
         1:       mask = '1;
         2:       mask = $urandom;
         default: mask = $urandom & $urandom & $urandom;
      endcase
      case ($urandom_range(0, 7))
         0:       len = 6'($urandom_range(1, 4));
         1, 2, 3: len = 6'($urandom_range(2, 8));
         4:       len = 6'($urandom_range(9, 32));
         5:       len = 6'd32;
         6:       len = 6'd0;
         default: len = 6'($urandom_range(33, 63));
      endcase
      case ($urandom_range(0, 3))
         0:       base = '0;
         1:       base = '1 - ADDR_BITS'($urandom_range(0, 40));
         default: base = {16'($urandom), $urandom};
      endcase
      csr_write(REG_WILDCARD, 64'(mask));
      csr_write(REG_LENGTH, 64'(len));
      csr_write(REG_BASE, 64'(base));
      setups_done++;
   endtask

   // random image, mostly with the signature planted somewhere in it
   task automatic queue_image(input bit plant);
      logic [7:0] img [$];
      int         eff;
      int         n;
      int         at;
      eff = active_length();
      n   = $urandom_range(1, eff + 10);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0)
            img.insert(img.size(), pattern_at($urandom_range(0, eff - 1)));
         else img.insert(img.size(), 8'($urandom_range(0, 255)));
      end
      if (plant && n >= eff) begin
         at = $urandom_range(0, n - eff);
         for (int j = 0; j < eff; j++)
            if (!wild_mask[j]) img[at+j] = pattern_at(j);
      end
      for (int i = 0; i < n; i++) push_beat(img[i], i == n - 1);
   endtask

   initial begin
      int phase;
      for (int w = 0; w < SIG_WORDS; w++) sig_word[w] = '0;
      wild_mask = '0;
      sig_len   = 6'd1;
      base_addr = '0;
      clear_scan();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setup: one-byte signature 00, match on final byte
      push_beat(8'hFF, 1'b0);
      push_beat(8'h00, 1'b1);
      settle();

      // DE ?? BE EF, base near top so the address wraps
      csr_write(REG_SIG_0_7, 64'h0000_0000_EFBE_ADDE);
      csr_write(REG_WILDCARD, 64'h0000_0000_0000_0002);
      csr_write(REG_LENGTH, 64'd4);
      csr_write(REG_BASE, 64'h0000_FFFF_FFFF_FFFE);
      csr_write(UNUSED_INDEX, '1);
      push_beat(8'h11, 1'b0);
      push_beat(8'h22, 1'b0);
      push_beat(8'hDE, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hBE, 1'b0);
      push_beat(8'hEF, 1'b0);
      push_beat(8'h55, 1'b1);
      push_beat(8'hDE, 1'b0);
      push_beat(8'hAD, 1'b0);
      push_beat(8'hBE, 1'b1);
      push_beat(8'hDE, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hBE, 1'b0);
      push_beat(8'hEF, 1'b1);
      settle();

      // zero length acts as one
      csr_write(REG_SIG_0_7, 64'h0000_0000_0000_00FF);
      csr_write(REG_WILDCARD, 64'h0);
      csr_write(REG_LENGTH, 64'd0);
      csr_write(REG_BASE, 64'h0000_0000_0000_0123);
      push_beat(8'h7F, 1'b0);
      push_beat(8'hFF, 1'b1);
      settle();

      // oversize length clamps to 32, stream too short
      csr_write(REG_WILDCARD, '1);
      csr_write(REG_LENGTH, 64'd63);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hA5, 1'b1);

      phase = 0;
      while (beats_queued < BEAT_TARGET) begin
         settle();
         no_idle = (phase == 5 || phase == 6);
         randomize_setup();
         repeat ($urandom_range(3, 8)) queue_image($urandom_range(0, 9) < 7);
         phase++;
      end
      settle();
      no_idle = 1'b0;
      repeat (20) @(posedge clock);

      $display("scanned %0d bytes in %0d images over %0d register setups", beats_accepted,
               images_queued, setups_done + 4);
      $display("reports checked: %0d matches, %0d misses", matches_seen, misses_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
